/* hw/rtl/pafss_pkg.sv */
// Types and constants shared by the pull/ack file send sequencer modules.
package pafss_pkg;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int CURSOR_W = 16;
    localparam int ACTION_W = 3;
    localparam int CHUNK_W  = 13;
    localparam int SIZE_W   = 17;
    localparam int LIMIT_W  = 8;
    localparam int BASE_W   = CURSOR_W + CHUNK_W;
    localparam int INDEX_W  = 2;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

    // Ack kinds
    localparam logic [KIND_W-1:0] KIND_DESC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PKG  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

    // Ack status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CHECK_ERR = 2'd2;

    // Transfer phases
    localparam logic [1:0] PH_DESC = 2'd0;
    localparam logic [1:0] PH_PKG  = 2'd1;
    localparam logic [1:0] PH_END  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    // Result actions
    localparam logic [ACTION_W-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DESC    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PKG     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_END     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FIN     = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_REFUSED = 3'd5;

    // Configuration register indexes
    localparam logic [INDEX_W-1:0] REG_CHUNK    = 2'd0;
    localparam logic [INDEX_W-1:0] REG_FILE     = 2'd1;
    localparam logic [INDEX_W-1:0] REG_METADATA = 2'd2;
    localparam logic [INDEX_W-1:0] REG_POLL     = 2'd3;

    // Reset values of the configuration registers and the substitute for a zero chunk
    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 13'd256;
    localparam logic [LIMIT_W-1:0] POLL_RESET  = 8'd10;
    localparam logic [CHUNK_W-1:0] CHUNK_ZERO_AS = 13'd256;

    typedef struct packed {
        logic [CHUNK_W-1:0] chunk_bytes;
        logic [SIZE_W-1:0]  file_bytes;
        logic               metadata_only;
        logic [LIMIT_W-1:0] poll_limit;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [KIND_W-1:0]   ack_kind;
        logic [STATUS_W-1:0] ack_status;
        logic [CURSOR_W-1:0] ack_cursor;
    } item_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CURSOR_W-1:0] package_number;
        logic [CURSOR_W-1:0] package_offset;
        logic [CHUNK_W-1:0]  package_length;
        logic                success;
    } result_t;

    // Outcome of a package request at the held cursor
    typedef struct packed {
        logic                past_end;
        logic [CURSOR_W-1:0] number;
        logic [CURSOR_W-1:0] offset;
        logic [CHUNK_W-1:0]  length;
    } pull_t;

endpackage

/* hw/rtl/pull_ack_file_send_sequencer.sv */
// Top level of the pull/ack file send sequencer: config, input and result registers.
//
// Usage:
//   s_axis carries events: tuser is the mode (poll tick, peer ack, start),
//   tdata the ack kind, status and requested package index.
//   m_axis carries one result per event: tuser is the action (none, send
//   descriptor, send package, send end, finished, start refused), tdata the
//   package number, byte offset, length and the success flag.
//   The config port writes chunk size, file size, metadata-only flag and
//   poll limit; write it only while no event is in flight.
// Path: an event passes the input register, then one pass of decision logic
//   into the result register. Throughput is one event per cycle while
//   m_axis_tready is high; the decision path holds a 16x13 multiply.
// Reset: the sender goes idle (done phase, no held ack, idle count zero) and
//   the config registers take their defaults (256, 0, 0, 10).
// Stall: while m_axis_tready is low a result is held; one more event waits
//   in the input register, then s_axis_tready drops.
module pull_ack_file_send_sequencer #(
    parameter int IMAGE_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    // Event stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [1:0] ack_kind, [3:2] ack_status, [19:4] ack_cursor
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] package_number, [31:16] package_offset,
                                        // [44:32] package_length, [45] success
    output logic [2:0]  m_axis_tuser    // [2:0] action
);

    pafss_pkg::cfg_t     cfg_reg;
    pafss_pkg::item_t    item_reg;
    logic                item_valid_reg;
    pafss_pkg::result_t  result;
    pafss_pkg::result_t  out_reg;
    logic                out_valid_reg;
    logic                advance;
    logic                fire;

    // Move the input stage on when the result register is free or draining
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = item_valid_reg && advance;
    assign s_axis_tready = !item_valid_reg || advance;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chunk_bytes   <= pafss_pkg::CHUNK_RESET;
            cfg_reg.file_bytes    <= '0;
            cfg_reg.metadata_only <= 1'b0;
            cfg_reg.poll_limit    <= pafss_pkg::POLL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pafss_pkg::REG_CHUNK:    cfg_reg.chunk_bytes   <= cfg_data[12:0];
                pafss_pkg::REG_FILE:     cfg_reg.file_bytes    <= cfg_data;
                pafss_pkg::REG_METADATA: cfg_reg.metadata_only <= cfg_data[0];
                pafss_pkg::REG_POLL:     cfg_reg.poll_limit    <= cfg_data[7:0];
                default:                 cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            item_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg.mode       <= s_axis_tuser;
            item_reg.ack_kind   <= s_axis_tdata[1:0];
            item_reg.ack_status <= s_axis_tdata[3:2];
            item_reg.ack_cursor <= s_axis_tdata[19:4];
        end
    end

    pafss_ctrl #(
        .IMAGE_BYTES (IMAGE_BYTES)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .fire   (fire),
        .item   (item_reg),
        .result (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.action;
    assign m_axis_tdata  = {2'b00, out_reg.success, out_reg.package_length,
                            out_reg.package_offset, out_reg.package_number};

endmodule

/* hw/rtl/pafss_pull.sv */
// Package base, length and end-of-file test for a requested package index.
module pafss_pull #(
    parameter int IMAGE_BYTES = 65536
) (
    input  pafss_pkg::cfg_t                  cfg,
    input  logic [pafss_pkg::CURSOR_W-1:0]   cursor,
    output pafss_pkg::pull_t                 pull
);

    localparam int SIZE_MAX = (1 << pafss_pkg::SIZE_W) - 1;
    localparam logic [pafss_pkg::SIZE_W-1:0] SIZE_CAP =
        (IMAGE_BYTES > SIZE_MAX) ? pafss_pkg::SIZE_W'(SIZE_MAX)
                                 : pafss_pkg::SIZE_W'(IMAGE_BYTES);
    localparam bit CAP_ACTIVE = (IMAGE_BYTES < SIZE_MAX);

    logic [pafss_pkg::CHUNK_W-1:0] chunk;
    logic [pafss_pkg::SIZE_W-1:0]  size;
    logic [pafss_pkg::BASE_W-1:0]  base;
    logic [pafss_pkg::SIZE_W-1:0]  remain;

    // Zero chunk counts as the default chunk; clamp the file to the image
    always_comb
    begin
        chunk = (cfg.chunk_bytes == '0) ? pafss_pkg::CHUNK_ZERO_AS : cfg.chunk_bytes;
        size  = (CAP_ACTIVE && (cfg.file_bytes > SIZE_CAP)) ? SIZE_CAP : cfg.file_bytes;
    end

    // Byte base of the package and the bytes left from there
    always_comb
    begin
        base   = pafss_pkg::BASE_W'(cursor) * pafss_pkg::BASE_W'(chunk);
        remain = size - base[pafss_pkg::SIZE_W-1:0];
    end

    always_comb
    begin
        pull.past_end = (base >= pafss_pkg::BASE_W'(size));
        pull.number   = cursor;
        pull.offset   = base[pafss_pkg::CURSOR_W-1:0];
        pull.length   = (remain > pafss_pkg::SIZE_W'(chunk)) ? chunk
                                                        : remain[pafss_pkg::CHUNK_W-1:0];
    end

endmodule

/* hw/rtl/pafss_ctrl.sv */
// Transfer state and per-item decision logic of the send sequencer.
module pafss_ctrl #(
    parameter int IMAGE_BYTES = 65536
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pafss_pkg::cfg_t      cfg,
    input  logic                 fire,
    input  pafss_pkg::item_t     item,
    output pafss_pkg::result_t   result
);

    logic                             busy_reg, busy_next;
    logic [1:0]                       phase_reg, phase_next;
    logic                             waiting_reg, waiting_next;
    logic [pafss_pkg::KIND_W-1:0]     kind_reg, kind_next;
    logic [pafss_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [pafss_pkg::CURSOR_W-1:0]   cursor_reg, cursor_next;
    logic [pafss_pkg::LIMIT_W-1:0]    idle_reg, idle_next;
    logic [pafss_pkg::LIMIT_W:0]      idle_inc;
    pafss_pkg::pull_t                 pull;

    pafss_pull #(
        .IMAGE_BYTES (IMAGE_BYTES)
    ) u_pull (
        .cfg    (cfg),
        .cursor (cursor_reg),
        .pull   (pull)
    );

    assign idle_inc = {1'b0, idle_reg} + 1'b1;

    // Decide the result and the next state for the current item
    always_comb
    begin
        busy_next    = busy_reg;
        phase_next   = phase_reg;
        waiting_next = waiting_reg;
        kind_next    = kind_reg;
        status_next  = status_reg;
        cursor_next  = cursor_reg;
        idle_next    = idle_reg;
        result       = '0;
        result.action = pafss_pkg::ACT_NONE;

        unique case (item.mode)
            pafss_pkg::MODE_START:
            begin
                if (busy_reg)
                begin
                    result.action = pafss_pkg::ACT_REFUSED;
                end
                else
                begin
                    busy_next     = 1'b1;
                    phase_next    = pafss_pkg::PH_DESC;
                    waiting_next  = 1'b0;
                    idle_next     = '0;
                    result.action = pafss_pkg::ACT_DESC;
                end
            end
            pafss_pkg::MODE_ACK:
            begin
                // Latch the latest ack; a newer one overwrites an unconsumed one
                if (busy_reg)
                begin
                    waiting_next = 1'b1;
                    kind_next    = item.ack_kind;
                    status_next  = item.ack_status;
                    cursor_next  = item.ack_cursor;
                end
            end
            pafss_pkg::MODE_TICK:
            begin
                if (busy_reg && !waiting_reg)
                begin
                    // Count an idle tick, saturating, and time out at the limit
                    idle_next = idle_inc[pafss_pkg::LIMIT_W] ? '1
                                                             : idle_inc[pafss_pkg::LIMIT_W-1:0];
                    if (idle_inc >= {1'b0, cfg.poll_limit})
                    begin
                        busy_next     = 1'b0;
                        phase_next    = pafss_pkg::PH_DONE;
                        result.action = pafss_pkg::ACT_FIN;
                    end
                end
                else if (busy_reg)
                begin
                    // Consume the held ack
                    waiting_next = 1'b0;
                    idle_next    = '0;
                    priority if ((phase_reg == pafss_pkg::PH_DESC)
                                 && (kind_reg == pafss_pkg::KIND_DESC))
                    begin
                        if (status_reg != pafss_pkg::STATUS_OK)
                        begin
                            busy_next     = 1'b0;
                            phase_next    = pafss_pkg::PH_DONE;
                            result.action = pafss_pkg::ACT_FIN;
                        end
                        else if (cfg.metadata_only || pull.past_end)
                        begin
                            phase_next    = pafss_pkg::PH_END;
                            result.action = pafss_pkg::ACT_END;
                        end
                        else
                        begin
                            phase_next            = pafss_pkg::PH_PKG;
                            result.action         = pafss_pkg::ACT_PKG;
                            result.package_number = pull.number;
                            result.package_offset = pull.offset;
                            result.package_length = pull.length;
                        end
                    end
                    else if ((phase_reg == pafss_pkg::PH_PKG)
                             && (kind_reg == pafss_pkg::KIND_PKG))
                    begin
                        if (status_reg == pafss_pkg::STATUS_CHECK_ERR)
                        begin
                            busy_next     = 1'b0;
                            phase_next    = pafss_pkg::PH_DONE;
                            result.action = pafss_pkg::ACT_FIN;
                        end
                        else if (pull.past_end)
                        begin
                            phase_next    = pafss_pkg::PH_END;
                            result.action = pafss_pkg::ACT_END;
                        end
                        else
                        begin
                            result.action         = pafss_pkg::ACT_PKG;
                            result.package_number = pull.number;
                            result.package_offset = pull.offset;
                            result.package_length = pull.length;
                        end
                    end
                    else if ((phase_reg == pafss_pkg::PH_END)
                             && (kind_reg == pafss_pkg::KIND_DONE))
                    begin
                        busy_next      = 1'b0;
                        phase_next     = pafss_pkg::PH_DONE;
                        result.action  = pafss_pkg::ACT_FIN;
                        result.success = (status_reg == pafss_pkg::STATUS_OK);
                    end
                    else
                    begin
                        // Drop an ack of the wrong kind
                        result.action = pafss_pkg::ACT_NONE;
                    end
                end
            end
            default:
            begin
                result.action = pafss_pkg::ACT_NONE;
            end
        endcase
    end

    // Advance the transfer state on each item taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            phase_reg   <= pafss_pkg::PH_DONE;
            waiting_reg <= 1'b0;
            kind_reg    <= '0;
            status_reg  <= '0;
            cursor_reg  <= '0;
            idle_reg    <= '0;
        end
        else if (fire)
        begin
            busy_reg    <= busy_next;
            phase_reg   <= phase_next;
            waiting_reg <= waiting_next;
            kind_reg    <= kind_next;
            status_reg  <= status_next;
            cursor_reg  <= cursor_next;
            idle_reg    <= idle_next;
        end
    end

endmodule

/* test/pafss_result_checker.sv */
// Predictor and scoreboard for the pull/ack file send sequencer result stream.
`timescale 1ns / 1ps

module pafss_result_checker #(
    parameter int IMAGE_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [1:0] ack_kind, [3:2] ack_status, [19:4] ack_cursor
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // [15:0] package_number, [31:16] package_offset,
                                        // [44:32] package_length, [45] success
    input  logic [2:0]  m_axis_tuser,   // [2:0] action
    output int          mismatch_count,
    output int          pending_results
);

    // Shadow copy of the configuration registers
    logic [pafss_pkg::CHUNK_W-1:0] chunk_bytes;
    logic [pafss_pkg::SIZE_W-1:0]  file_bytes;
    logic                          metadata_only;
    logic [pafss_pkg::LIMIT_W-1:0] poll_limit;

    // Shadow copy of the sender state
    logic                           busy;
    logic [1:0]                     phase;
    logic                           ack_held;
    logic [pafss_pkg::KIND_W-1:0]   held_kind;
    logic [pafss_pkg::STATUS_W-1:0] held_status;
    logic [pafss_pkg::CURSOR_W-1:0] held_cursor;
    logic [7:0]                     idle_ticks;

    pafss_pkg::result_t expected_actions[$];

    function automatic pafss_pkg::result_t finish_transfer(input logic ok);
        pafss_pkg::result_t r;
        r = '0;
        busy = 1'b0;
        phase = pafss_pkg::PH_DONE;
        r.action = pafss_pkg::ACT_FIN;
        r.success = ok;
        return r;
    endfunction

    // Send the package at the cursor, or the end message once past the file
    function automatic pafss_pkg::result_t pull_package(
        input logic [pafss_pkg::CURSOR_W-1:0] cursor);
        pafss_pkg::result_t r;
        longint unsigned chunk, size, base, len;
        r = '0;
        chunk = (chunk_bytes == '0) ? longint'(pafss_pkg::CHUNK_ZERO_AS)
                                    : longint'(chunk_bytes);
        size = (file_bytes > IMAGE_BYTES) ? longint'(IMAGE_BYTES) : longint'(file_bytes);
        base = longint'(cursor) * chunk;
        if (base >= size)
        begin
            phase = pafss_pkg::PH_END;
            r.action = pafss_pkg::ACT_END;
        end
        else
        begin
            phase = pafss_pkg::PH_PKG;
            len = size - base;
            if (len > chunk)
                len = chunk;
            r.action = pafss_pkg::ACT_PKG;
            r.package_number = cursor;
            r.package_offset = base[15:0];
            r.package_length = len[12:0];
        end
        return r;
    endfunction

    // Consume the held ack according to the current phase
    function automatic pafss_pkg::result_t take_ack();
        pafss_pkg::result_t r;
        r = '0;
        ack_held = 1'b0;
        idle_ticks = '0;
        case (phase)
            pafss_pkg::PH_DESC:
                if (held_kind == pafss_pkg::KIND_DESC)
                begin
                    if (held_status != pafss_pkg::STATUS_OK)
                        r = finish_transfer(1'b0);
                    else if (metadata_only)
                    begin
                        phase = pafss_pkg::PH_END;
                        r.action = pafss_pkg::ACT_END;
                    end
                    else
                        r = pull_package(held_cursor);
                end
            pafss_pkg::PH_PKG:
                if (held_kind == pafss_pkg::KIND_PKG)
                begin
                    if (held_status == pafss_pkg::STATUS_CHECK_ERR)
                        r = finish_transfer(1'b0);
                    else
                        r = pull_package(held_cursor);
                end
            pafss_pkg::PH_END:
                if (held_kind == pafss_pkg::KIND_DONE)
                    r = finish_transfer(held_status == pafss_pkg::STATUS_OK);
            default: ;
        endcase
        return r;
    endfunction

    // Advance the shadow state by one item and return the action it causes
    function automatic pafss_pkg::result_t next_action(input pafss_pkg::item_t ev);
        pafss_pkg::result_t r;
        int unsigned next_idle;
        r = '0;
        case (ev.mode)
            pafss_pkg::MODE_START:
                if (busy)
                    r.action = pafss_pkg::ACT_REFUSED;
                else
                begin
                    busy = 1'b1;
                    phase = pafss_pkg::PH_DESC;
                    ack_held = 1'b0;
                    idle_ticks = '0;
                    r.action = pafss_pkg::ACT_DESC;
                end
            pafss_pkg::MODE_ACK:
                if (busy)
                begin
                    ack_held = 1'b1;
                    held_kind = ev.ack_kind;
                    held_status = ev.ack_status;
                    held_cursor = ev.ack_cursor;
                end
            pafss_pkg::MODE_TICK:
                if (busy)
                begin
                    if (ack_held)
                        r = take_ack();
                    else
                    begin
                        next_idle = int'(idle_ticks) + 1;
                        idle_ticks = (next_idle > 255) ? 8'd255 : next_idle[7:0];
                        if (next_idle >= int'(poll_limit))
                            r = finish_transfer(1'b0);
                    end
                end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Track config writes, predict on each accepted item, compare each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        pafss_pkg::item_t   ev;
        pafss_pkg::result_t got;
        pafss_pkg::result_t want;
        if (!rst_n)
        begin
            chunk_bytes = pafss_pkg::CHUNK_RESET;
            file_bytes = '0;
            metadata_only = 1'b0;
            poll_limit = pafss_pkg::POLL_RESET;
            busy = 1'b0;
            phase = pafss_pkg::PH_DONE;
            ack_held = 1'b0;
            held_kind = '0;
            held_status = '0;
            held_cursor = '0;
            idle_ticks = '0;
            expected_actions.delete();
            mismatch_count = 0;
            pending_results = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pafss_pkg::REG_CHUNK:    chunk_bytes = cfg_data[pafss_pkg::CHUNK_W-1:0];
                    pafss_pkg::REG_FILE:     file_bytes = cfg_data[pafss_pkg::SIZE_W-1:0];
                    pafss_pkg::REG_METADATA: metadata_only = cfg_data[0];
                    pafss_pkg::REG_POLL:     poll_limit = cfg_data[pafss_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.action = m_axis_tuser;
                got.package_number = m_axis_tdata[15:0];
                got.package_offset = m_axis_tdata[31:16];
                got.package_length = m_axis_tdata[44:32];
                got.success = m_axis_tdata[45];
                if (expected_actions.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual action %0d",
                             $time, got.action);
                end
                else
                begin
                    want = expected_actions.pop_front();
                    check_field("action", want.action, got.action);
                    check_field("package_number", want.package_number, got.package_number);
                    check_field("package_offset", want.package_offset, got.package_offset);
                    check_field("package_length", want.package_length, got.package_length);
                    check_field("success", want.success, got.success);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                ev.mode = s_axis_tuser;
                ev.ack_kind = s_axis_tdata[1:0];
                ev.ack_status = s_axis_tdata[3:2];
                ev.ack_cursor = s_axis_tdata[19:4];
                expected_actions.push_back(next_action(ev));
            end
            pending_results = expected_actions.size();
        end
    end

endmodule

/* test/tb_pull_ack_file_send_sequencer.sv */
// Stimulus, clock, reset and verdict for the pull/ack file send sequencer.
`timescale 1ns / 1ps

module tb_pull_ack_file_send_sequencer;

    localparam int IMAGE_BYTES = 65536;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PASS = 230;
    localparam logic [pafss_pkg::KIND_W-1:0]   KIND_OTHER     = 2'd3;
    localparam logic [pafss_pkg::STATUS_W-1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [pafss_pkg::STATUS_W-1:0] STATUS_OTHER   = 2'd3;
    localparam logic [pafss_pkg::CURSOR_W-1:0] CURSOR_MAX     = 16'hFFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [1:0] ack_kind, [3:2] ack_status, [19:4] ack_cursor
    logic [1:0]  s_axis_tuser = '0;   // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // [15:0] package_number, [31:16] package_offset,
                                      // [44:32] package_length, [45] success
    logic [2:0]  m_axis_tuser;        // [2:0] action

    int mismatch_count;
    int pending_results;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request = 1'b0;
    int items_sent = 0;
    int package_count = 1;

    pull_ack_file_send_sequencer #(
        .IMAGE_BYTES(IMAGE_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    pafss_result_checker #(
        .IMAGE_BYTES(IMAGE_BYTES)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .mismatch_count(mismatch_count),
        .pending_results(pending_results)
    );

    always #1 clk = ~clk;

    // Drive result ready: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // End the run when nothing moves on either side for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_pull_ack_file_send_sequencer: errors");
        $finish;
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic send_event(input logic [1:0] mode,
                              input logic [pafss_pkg::KIND_W-1:0] kind,
                              input logic [pafss_pkg::STATUS_W-1:0] status,
                              input logic [pafss_pkg::CURSOR_W-1:0] cursor);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = mode;
        s_axis_tdata = {4'b0, cursor, status, kind};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic poll_tick();
        send_event(pafss_pkg::MODE_TICK, 2'($urandom), 2'($urandom), 16'($urandom));
    endtask

    task automatic send_noise();
        send_event(2'($urandom), 2'($urandom), 2'($urandom), 16'($urandom));
    endtask

    // Pause the sender until every expected result has come back
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [pafss_pkg::INDEX_W-1:0] index,
                             input logic [16:0] value);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Choose and write a new setting, extremes included
    task automatic pick_settings();
        logic [16:0] chunk;
        logic [16:0] size;
        logic [16:0] poll;
        int eff_chunk;
        int eff_size;
        case ($urandom_range(9))
            0: chunk = 17'd0;
            1: chunk = 17'd1;
            2: chunk = 17'd4096;
            3: chunk = 17'd8191;
            default: chunk = 17'($urandom_range(1, 600));
        endcase
        case ($urandom_range(9))
            0: size = 17'd0;
            1: size = 17'd65536;
            2: size = 17'h1FFFF;
            default: size = 17'($urandom_range(0, 2500));
        endcase
        case ($urandom_range(9))
            0: poll = 17'd0;
            1: poll = 17'd1;
            2: poll = 17'd255;
            default: poll = 17'($urandom_range(2, 40));
        endcase
        write_reg(pafss_pkg::REG_CHUNK, chunk);
        write_reg(pafss_pkg::REG_FILE, size);
        write_reg(pafss_pkg::REG_METADATA, 17'($urandom_range(7) == 0));
        write_reg(pafss_pkg::REG_POLL, poll);
        eff_chunk = (chunk == 0) ? 256 : int'(chunk);
        eff_size = (size > IMAGE_BYTES) ? IMAGE_BYTES : int'(size);
        package_count = (eff_size + eff_chunk - 1) / eff_chunk;
    endtask

    // Deliver an ack and the tick that consumes it, with occasional idle ticks and noise
    task automatic deliver_ack(input logic [pafss_pkg::KIND_W-1:0] kind,
                               input logic [pafss_pkg::STATUS_W-1:0] status,
                               input logic [pafss_pkg::CURSOR_W-1:0] cursor);
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 3)) poll_tick();
        if ($urandom_range(11) == 0)
            send_noise();
        send_event(pafss_pkg::MODE_ACK, kind, status, cursor);
        poll_tick();
    endtask

    // One well-formed transfer with random content and some breakage
    task automatic run_transfer();
        int k;
        int last_pkg;
        send_event(pafss_pkg::MODE_START, 2'($urandom), 2'($urandom), 16'($urandom));
        if ($urandom_range(9) == 0)
            send_event(pafss_pkg::MODE_START, 2'($urandom), 2'($urandom), 16'($urandom));
        deliver_ack(pafss_pkg::KIND_DESC,
                    ($urandom_range(11) == 0) ? 2'($urandom_range(1, 3))
                                              : pafss_pkg::STATUS_OK, '0);
        last_pkg = (package_count > 10) ? 10 : package_count;
        k = 0;
        while (k < last_pkg)
        begin
            case ($urandom_range(24))
                0:       deliver_ack(pafss_pkg::KIND_PKG, pafss_pkg::STATUS_CHECK_ERR, 16'(k));
                1, 2:    deliver_ack(pafss_pkg::KIND_PKG, STATUS_CRC_ERR, 16'(k));
                3:       deliver_ack(pafss_pkg::KIND_PKG, STATUS_OTHER, 16'(k));
                4:       deliver_ack(pafss_pkg::KIND_PKG, pafss_pkg::STATUS_OK, 16'($urandom));
                5:       deliver_ack(KIND_OTHER, 2'($urandom), 16'(k));
                default:
                begin
                    k++;
                    deliver_ack(pafss_pkg::KIND_PKG, pafss_pkg::STATUS_OK, 16'(k));
                end
            endcase
        end
        // jump past the end of a long file
        if (package_count > last_pkg)
            deliver_ack(pafss_pkg::KIND_PKG, pafss_pkg::STATUS_OK, CURSOR_MAX);
        deliver_ack(pafss_pkg::KIND_DONE,
                    ($urandom_range(7) == 0) ? 2'($urandom_range(1, 3))
                                             : pafss_pkg::STATUS_OK,
                    16'($urandom));
    endtask

    initial
    begin
        int target;
        bit hold_done;
        hold_done = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: idle behavior, refusal, dropped ack, empty file
        poll_tick();
        send_event(pafss_pkg::MODE_ACK, pafss_pkg::KIND_DESC, pafss_pkg::STATUS_OK, CURSOR_MAX);
        send_event(pafss_pkg::MODE_NOP, KIND_OTHER, STATUS_OTHER, CURSOR_MAX);
        send_event(pafss_pkg::MODE_START, '0, '0, '0);
        send_event(pafss_pkg::MODE_START, KIND_OTHER, STATUS_OTHER, CURSOR_MAX);
        send_event(pafss_pkg::MODE_ACK, pafss_pkg::KIND_PKG, pafss_pkg::STATUS_OK, '0);
        poll_tick();
        send_event(pafss_pkg::MODE_ACK, pafss_pkg::KIND_DESC, pafss_pkg::STATUS_OK, '0);
        poll_tick();
        send_event(pafss_pkg::MODE_ACK, pafss_pkg::KIND_DONE, pafss_pkg::STATUS_OK, '0);
        poll_tick();

        // Directed: zero chunk, short last package, resend, cursor past the end, overwrite
        wait_drained();
        write_reg(pafss_pkg::REG_CHUNK, 17'd0);
        write_reg(pafss_pkg::REG_FILE, 17'd1000);
        send_event(pafss_pkg::MODE_START, '0, '0, '0);
        send_event(pafss_pkg::MODE_ACK, pafss_pkg::KIND_DESC, pafss_pkg::STATUS_OK, 16'd3);
        poll_tick();
        send_event(pafss_pkg::MODE_ACK, pafss_pkg::KIND_PKG, STATUS_CRC_ERR, 16'd1);
        poll_tick();
        send_event(pafss_pkg::MODE_ACK, pafss_pkg::KIND_PKG, STATUS_OTHER, CURSOR_MAX);
        poll_tick();
        send_event(pafss_pkg::MODE_ACK, pafss_pkg::KIND_DONE, STATUS_CRC_ERR, '0);
        send_event(pafss_pkg::MODE_ACK, pafss_pkg::KIND_DONE, pafss_pkg::STATUS_OK, '0);
        poll_tick();

        // Directed: zero poll limit fails on the first idle tick
        wait_drained();
        write_reg(pafss_pkg::REG_POLL, 17'd0);
        send_event(pafss_pkg::MODE_START, '0, '0, '0);
        poll_tick();

        // Directed: metadata only, failed done ack
        wait_drained();
        write_reg(pafss_pkg::REG_POLL, 17'd255);
        write_reg(pafss_pkg::REG_METADATA, 17'd1);
        send_event(pafss_pkg::MODE_START, '0, '0, '0);
        send_event(pafss_pkg::MODE_ACK, pafss_pkg::KIND_DESC, pafss_pkg::STATUS_OK, '0);
        poll_tick();
        send_event(pafss_pkg::MODE_ACK, pafss_pkg::KIND_DONE, STATUS_OTHER, '0);
        poll_tick();

        // Random passes: receiver-heavy idling, sender-heavy idling, then none
        for (int pass = 0; pass < 3; pass++)
        begin
            send_idle_pct = (pass == 0) ? 37 : (pass == 1) ? 48 : 0;
            recv_idle_pct = (pass == 0) ? 48 : (pass == 1) ? 37 : 0;
            target = items_sent + ITEMS_PER_PASS;
            while (items_sent < target)
            begin
                wait_drained();
                pick_settings();
                if (pass == 2 && !hold_done)
                begin
                    hold_request = 1'b1;
                    hold_done = 1'b1;
                end
                repeat (3)
                begin
                    run_transfer();
                    if ($urandom_range(3) == 0)
                        send_noise();
                end
            end
        end

        // Drain and give the verdict
        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("tb_pull_ack_file_send_sequencer: clean");
        else
            $display("tb_pull_ack_file_send_sequencer: errors");
        $finish;
    end

endmodule
